// ===== src/q2a_pkg.sv =====
`default_nettype none
package q2a_pkg;

   localparam int DATA_WIDTH    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int PRESCALE      = 12;
   localparam int PW            = 34;
   localparam int XW            = DATA_WIDTH + PRESCALE + 5;
   localparam int ZW            = 29;
   localparam int SHW           = 5;
   localparam int GW            = 30;
   localparam int MW            = XW - 1 + GW;
   localparam int LAT           = CORDIC_STAGES + 1;
   localparam int DEPTH         = 2 * LAT + 4;

   localparam logic signed [ZW-1:0] PI_Q24      = ZW'(52707179);
   localparam logic [GW-1:0]        INV_GAIN_Q30 = GW'(652032874);

   localparam logic KIND_MATRIX = 1'b0;
   localparam logic KIND_ANGLES = 1'b1;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] omega_x;
      logic signed [15:0] omega_y;
      logic signed [15:0] omega_z;
   } req_item_type;

   typedef struct packed {
      logic               kind;
      logic               last;
      logic signed [15:0] slot0;
      logic signed [15:0] slot1;
      logic signed [15:0] slot2;
      logic signed [15:0] slot3;
      logic signed [15:0] slot4;
      logic signed [15:0] slot5;
      logic signed [15:0] slot6;
      logic signed [15:0] slot7;
      logic signed [15:0] slot8;
   } rsp_item_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } cordic_vec_type;

   function automatic logic signed [ZW-1:0] atan_q24(input logic [SHW-1:0] i);
      logic signed [ZW-1:0] r;
      case (i)
         5'd0:  r = ZW'(13176795);
         5'd1:  r = ZW'(7778716);
         5'd2:  r = ZW'(4110060);
         5'd3:  r = ZW'(2086331);
         5'd4:  r = ZW'(1047214);
         5'd5:  r = ZW'(524117);
         5'd6:  r = ZW'(262123);
         5'd7:  r = ZW'(131069);
         5'd8:  r = ZW'(65536);
         5'd9:  r = ZW'(32768);
         5'd10: r = ZW'(16384);
         5'd11: r = ZW'(8192);
         5'd12: r = ZW'(4096);
         5'd13: r = ZW'(2048);
         5'd14: r = ZW'(1024);
         5'd15: r = ZW'(512);
         5'd16: r = ZW'(256);
         5'd17: r = ZW'(128);
         5'd18: r = ZW'(64);
         5'd19: r = ZW'(32);
         5'd20: r = ZW'(16);
         5'd21: r = ZW'(8);
         5'd22: r = ZW'(4);
         5'd23: r = ZW'(2);
         5'd24: r = ZW'(1);
         5'd25: r = ZW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int n);
      logic signed [63:0] one;
      one = 64'sd1;
      return (v + (one <<< (n - 1))) >>> n;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      logic signed [63:0] r;
      hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      r  = (v > hi) ? hi : ((v < lo) ? lo : v);
      return DATA_WIDTH'(r);
   endfunction

endpackage
`default_nettype wire

// ===== src/quaternion_to_attitude_top.sv =====
// Channel   Ports                       Handshake
// request   start, busy, req_item       taken when start is high and busy is low
// response  rsp_strobe, rsp_item        one item per strobe, cannot be held off
//
// Each request gives two response items on consecutive cycles: the matrix, then
// the rates and angles.
// Busy is high for one cycle after each accepted item, since the response port
// carries two items per request, so back-to-back requests are not taken.
// Synchronous reset clears only busy, the valid pipeline and the response strobe.
`default_nettype none
module quaternion_to_attitude_top
   import q2a_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_item_type req_item,
   output logic              rsp_strobe,
   output rsp_item_type      rsp_item
);

   typedef logic signed [DATA_WIDTH-1:0] dval_type;

   logic                 busy_ff;
   logic [DEPTH-1:0]     vld_ff;
   logic signed [31:0]   mp_ff [10];
   logic signed [31:0]   rp_ff [12];
   dval_type             a_ff [9];
   dval_type             r_ff [4];
   dval_type             a_in [9];
   dval_type             r_in [4];
   dval_type             a_dly_ff [2*LAT+2][9];
   dval_type             r_dly_ff [2*LAT+2][4];
   logic signed [ZW-1:0] roll_dly_ff [LAT+2];
   logic signed [ZW-1:0] yaw_dly_ff [LAT+2];
   logic [MW-1:0]        prod_ff;
   logic signed [XW-1:0] mag_ff;
   logic signed [XW-1:0] mag_in;
   logic signed [ZW-1:0] roll_z;
   logic signed [ZW-1:0] yaw_z;
   logic signed [ZW-1:0] hyp_z;
   logic signed [ZW-1:0] pitch_z;
   logic signed [XW-1:0] hyp_x;
   logic signed [XW-1:0] roll_x;
   logic signed [XW-1:0] yaw_x;
   logic signed [XW-1:0] pitch_x;
   logic signed [XW-1:0] x8;
   logic signed [XW-1:0] y7;
   logic signed [XW-1:0] x0;
   logic signed [XW-1:0] y3;
   logic signed [XW-1:0] y6;
   logic                 accept;
   rsp_item_type         rsp_item_ff;
   rsp_item_type         pend_ff;
   logic                 rsp_strobe_ff;
   logic                 pend_vld_ff;
   dval_type             roll_a;
   dval_type             pitch_a;
   dval_type             yaw_a;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         vld_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         pend_vld_ff   <= 1'b0;
      end else begin
         busy_ff       <= accept;
         vld_ff        <= {vld_ff[DEPTH-2:0], accept};
         rsp_strobe_ff <= vld_ff[DEPTH-1] || pend_vld_ff;
         pend_vld_ff   <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      mp_ff[0]  <= req_item.quat_w * req_item.quat_w;
      mp_ff[1]  <= req_item.quat_x * req_item.quat_x;
      mp_ff[2]  <= req_item.quat_y * req_item.quat_y;
      mp_ff[3]  <= req_item.quat_z * req_item.quat_z;
      mp_ff[4]  <= req_item.quat_x * req_item.quat_y;
      mp_ff[5]  <= req_item.quat_w * req_item.quat_z;
      mp_ff[6]  <= req_item.quat_x * req_item.quat_z;
      mp_ff[7]  <= req_item.quat_w * req_item.quat_y;
      mp_ff[8]  <= req_item.quat_y * req_item.quat_z;
      mp_ff[9]  <= req_item.quat_w * req_item.quat_x;
      rp_ff[0]  <= req_item.quat_x * req_item.omega_x;
      rp_ff[1]  <= req_item.quat_y * req_item.omega_y;
      rp_ff[2]  <= req_item.quat_z * req_item.omega_z;
      rp_ff[3]  <= req_item.quat_w * req_item.omega_x;
      rp_ff[4]  <= req_item.quat_z * req_item.omega_y;
      rp_ff[5]  <= req_item.quat_y * req_item.omega_z;
      rp_ff[6]  <= req_item.quat_z * req_item.omega_x;
      rp_ff[7]  <= req_item.quat_w * req_item.omega_y;
      rp_ff[8]  <= req_item.quat_x * req_item.omega_z;
      rp_ff[9]  <= req_item.quat_y * req_item.omega_x;
      rp_ff[10] <= req_item.quat_x * req_item.omega_y;
      rp_ff[11] <= req_item.quat_w * req_item.omega_z;
   end

   always_comb begin
      logic signed [PW-1:0] half;
      half = PW'(1) <<< 27;
      a_in[0] = sat(64'(rnd_shift(64'(PW'(mp_ff[0]) + PW'(mp_ff[1]) - half), 13)));
      a_in[1] = sat(64'(rnd_shift(64'(PW'(mp_ff[4]) - PW'(mp_ff[5])), 13)));
      a_in[2] = sat(64'(rnd_shift(64'(PW'(mp_ff[6]) + PW'(mp_ff[7])), 13)));
      a_in[3] = sat(64'(rnd_shift(64'(PW'(mp_ff[4]) + PW'(mp_ff[5])), 13)));
      a_in[4] = sat(64'(rnd_shift(64'(PW'(mp_ff[0]) + PW'(mp_ff[2]) - half), 13)));
      a_in[5] = sat(64'(rnd_shift(64'(PW'(mp_ff[8]) - PW'(mp_ff[9])), 13)));
      a_in[6] = sat(64'(rnd_shift(64'(PW'(mp_ff[6]) - PW'(mp_ff[7])), 13)));
      a_in[7] = sat(64'(rnd_shift(64'(PW'(mp_ff[8]) + PW'(mp_ff[9])), 13)));
      a_in[8] = sat(64'(rnd_shift(64'(PW'(mp_ff[0]) + PW'(mp_ff[3]) - half), 13)));
      r_in[0] = sat(64'(rnd_shift(64'(-PW'(rp_ff[0]) - PW'(rp_ff[1])
                                      - PW'(rp_ff[2])), 15)));
      r_in[1] = sat(64'(rnd_shift(64'(PW'(rp_ff[3]) + PW'(rp_ff[4])
                                      - PW'(rp_ff[5])), 15)));
      r_in[2] = sat(64'(rnd_shift(64'(-PW'(rp_ff[6]) + PW'(rp_ff[7])
                                      + PW'(rp_ff[8])), 15)));
      r_in[3] = sat(64'(rnd_shift(64'(PW'(rp_ff[9]) - PW'(rp_ff[10])
                                      + PW'(rp_ff[11])), 15)));
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      r_ff <= r_in;
      a_dly_ff[0] <= a_ff;
      r_dly_ff[0] <= r_ff;
      for (int j = 1; j < 2*LAT+2; j++) begin
         a_dly_ff[j] <= a_dly_ff[j-1];
         r_dly_ff[j] <= r_dly_ff[j-1];
      end
      roll_dly_ff[0] <= roll_z;
      yaw_dly_ff[0]  <= yaw_z;
      for (int j = 1; j < LAT+2; j++) begin
         roll_dly_ff[j] <= roll_dly_ff[j-1];
         yaw_dly_ff[j]  <= yaw_dly_ff[j-1];
      end
      prod_ff <= MW'(hyp_x[XW-2:0]) * MW'(INV_GAIN_Q30);
      mag_ff  <= mag_in;
   end

   assign x8 = XW'(a_ff[8]) <<< PRESCALE;
   assign y7 = XW'(a_ff[7]) <<< PRESCALE;
   assign x0 = XW'(a_ff[0]) <<< PRESCALE;
   assign y3 = XW'(a_ff[3]) <<< PRESCALE;
   assign y6 = XW'(a_dly_ff[LAT+1][6]) <<< PRESCALE;
   assign mag_in = XW'((prod_ff + (MW'(1) << (GW - 1))) >> GW);

   q2a_cordic u_roll (
      .clock (clock), .x_in (x8), .y_in (-y7), .z_out (roll_z), .x_out (roll_x)
   );

   q2a_cordic u_hyp (
      .clock (clock), .x_in (x8), .y_in (y7), .z_out (hyp_z), .x_out (hyp_x)
   );

   q2a_cordic u_yaw (
      .clock (clock), .x_in (x0), .y_in (y3), .z_out (yaw_z), .x_out (yaw_x)
   );

   q2a_cordic u_pitch (
      .clock (clock), .x_in (mag_ff), .y_in (y6), .z_out (pitch_z), .x_out (pitch_x)
   );

   always_comb begin
      roll_a  = sat(rnd_shift(-64'(roll_dly_ff[LAT+1]), 12));
      pitch_a = sat(rnd_shift(64'(pitch_z), 12));
      yaw_a   = sat(rnd_shift(64'(yaw_dly_ff[LAT+1]), 12));
   end

   always_ff @(posedge clock) begin
      if (vld_ff[DEPTH-1]) begin
         rsp_item_ff.kind  <= KIND_MATRIX;
         rsp_item_ff.last  <= 1'b0;
         rsp_item_ff.slot0 <= 16'(a_dly_ff[2*LAT+1][0]);
         rsp_item_ff.slot1 <= 16'(a_dly_ff[2*LAT+1][1]);
         rsp_item_ff.slot2 <= 16'(a_dly_ff[2*LAT+1][2]);
         rsp_item_ff.slot3 <= 16'(a_dly_ff[2*LAT+1][3]);
         rsp_item_ff.slot4 <= 16'(a_dly_ff[2*LAT+1][4]);
         rsp_item_ff.slot5 <= 16'(a_dly_ff[2*LAT+1][5]);
         rsp_item_ff.slot6 <= 16'(a_dly_ff[2*LAT+1][6]);
         rsp_item_ff.slot7 <= 16'(a_dly_ff[2*LAT+1][7]);
         rsp_item_ff.slot8 <= 16'(a_dly_ff[2*LAT+1][8]);
      end else begin
         rsp_item_ff <= pend_ff;
      end
      pend_ff.kind  <= KIND_ANGLES;
      pend_ff.last  <= 1'b1;
      pend_ff.slot0 <= 16'(r_dly_ff[2*LAT+1][0]);
      pend_ff.slot1 <= 16'(r_dly_ff[2*LAT+1][1]);
      pend_ff.slot2 <= 16'(r_dly_ff[2*LAT+1][2]);
      pend_ff.slot3 <= 16'(r_dly_ff[2*LAT+1][3]);
      pend_ff.slot4 <= 16'(roll_a);
      pend_ff.slot5 <= 16'(pitch_a);
      pend_ff.slot6 <= 16'(yaw_a);
      pend_ff.slot7 <= '0;
      pend_ff.slot8 <= '0;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
`default_nettype wire

// ===== src/q2a_cordic_cell.sv =====
`default_nettype none
module q2a_cordic_cell
   import q2a_pkg::*;
(
   input  wire logic           clock,
   input  wire logic [SHW-1:0] shamt,
   input  wire cordic_vec_type cell_in,
   output cordic_vec_type      cell_out
);

   cordic_vec_type vec_ff;
   cordic_vec_type vec_in;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;

   always_comb begin
      xs = cell_in.x >>> shamt;
      ys = cell_in.y >>> shamt;
      vec_in.zero = cell_in.zero;
      if (!cell_in.y[XW-1]) begin
         vec_in.x = cell_in.x + ys;
         vec_in.y = cell_in.y - xs;
         vec_in.z = cell_in.z + atan_q24(shamt);
      end else begin
         vec_in.x = cell_in.x - ys;
         vec_in.y = cell_in.y + xs;
         vec_in.z = cell_in.z - atan_q24(shamt);
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   assign cell_out = vec_ff;

endmodule
`default_nettype wire

// ===== src/q2a_cordic.sv =====
`default_nettype none
module q2a_cordic
   import q2a_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic signed [XW-1:0] x_in,
   input  wire logic signed [XW-1:0] y_in,
   output logic signed [ZW-1:0]      z_out,
   output logic signed [XW-1:0]      x_out
);

   cordic_vec_type chain [CORDIC_STAGES+1];
   cordic_vec_type pre_ff;
   cordic_vec_type pre_in;

   always_comb begin
      pre_in.zero = (x_in == '0) && (y_in == '0);
      if (x_in[XW-1]) begin
         pre_in.x = -x_in;
         pre_in.y = -y_in;
         pre_in.z = y_in[XW-1] ? -PI_Q24 : PI_Q24;
      end else begin
         pre_in.x = x_in;
         pre_in.y = y_in;
         pre_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
   end

   assign chain[0] = pre_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      q2a_cordic_cell u_cell (
         .clock    (clock),
         .shamt    (SHW'(i)),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   assign z_out = chain[CORDIC_STAGES].zero ? '0 : chain[CORDIC_STAGES].z;
   assign x_out = chain[CORDIC_STAGES].x;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top
   import q2a_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM    = 2000;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN       = 2 * CORDIC_STAGES + 20;
   localparam int QF          = PRESCALE;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   rsp_item_type pending_rsp[$];
   int           mismatches = 0;
   int           items_sent = 0;
   int           rsp_seen   = 0;
   longint       cycles     = 0;

   quaternion_to_attitude_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   function automatic longint sra(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint round_sh(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clip(longint v);
      longint hi;
      hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   function automatic longint vec_angle(longint x, longint y, output longint magnitude);
      longint zacc, nx, ny;
      longint tab[26];
      tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
              65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
              16, 8, 4, 2, 1, 1};
      zacc = 0;
      if (x == 0 && y == 0) begin
         magnitude = 0;
         return 0;
      end
      if (x < 0) begin
         zacc = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (y >= 0) begin
            nx = x + sra(y, i);
            ny = y - sra(x, i);
            zacc += (i < 26) ? tab[i] : 0;
         end else begin
            nx = x - sra(y, i);
            ny = y + sra(x, i);
            zacc -= (i < 26) ? tab[i] : 0;
         end
         x = nx;
         y = ny;
      end
      magnitude = round_sh(x * 64'sd652032874, 30);
      return zacc;
   endfunction

   task automatic predict_attitude(input req_item_type q);
      longint e0, e1, e2, e3, wx, wy, wz, h, mag, unused;
      longint m[9];
      rsp_item_type mat, ang;
      e0 = q.quat_w; e1 = q.quat_x; e2 = q.quat_y; e3 = q.quat_z;
      wx = q.omega_x; wy = q.omega_y; wz = q.omega_z;
      h = 64'sd1 <<< 27;
      m[0] = clip(round_sh(e0 * e0 + e1 * e1 - h, 13));
      m[1] = clip(round_sh(e1 * e2 - e0 * e3, 13));
      m[2] = clip(round_sh(e1 * e3 + e0 * e2, 13));
      m[3] = clip(round_sh(e1 * e2 + e0 * e3, 13));
      m[4] = clip(round_sh(e0 * e0 + e2 * e2 - h, 13));
      m[5] = clip(round_sh(e2 * e3 - e0 * e1, 13));
      m[6] = clip(round_sh(e1 * e3 - e0 * e2, 13));
      m[7] = clip(round_sh(e2 * e3 + e0 * e1, 13));
      m[8] = clip(round_sh(e0 * e0 + e3 * e3 - h, 13));
      mat = '0;
      mat.kind = KIND_MATRIX;
      {mat.slot0, mat.slot1, mat.slot2, mat.slot3, mat.slot4, mat.slot5,
       mat.slot6, mat.slot7, mat.slot8} = {16'(m[0]), 16'(m[1]), 16'(m[2]),
       16'(m[3]), 16'(m[4]), 16'(m[5]), 16'(m[6]), 16'(m[7]), 16'(m[8])};
      ang = '0;
      ang.kind = KIND_ANGLES;
      ang.last = 1'b1;
      ang.slot0 = 16'(clip(round_sh(-e1 * wx - e2 * wy - e3 * wz, 15)));
      ang.slot1 = 16'(clip(round_sh(e0 * wx + e3 * wy - e2 * wz, 15)));
      ang.slot2 = 16'(clip(round_sh(-e3 * wx + e0 * wy + e1 * wz, 15)));
      ang.slot3 = 16'(clip(round_sh(e2 * wx - e1 * wy + e0 * wz, 15)));
      ang.slot4 = 16'(clip(round_sh(-vec_angle(m[8] <<< QF, -(m[7] <<< QF), unused), 12)));
      void'(vec_angle(m[8] <<< QF, m[7] <<< QF, mag));
      ang.slot5 = 16'(clip(round_sh(vec_angle(mag, m[6] <<< QF, unused), 12)));
      ang.slot6 = 16'(clip(round_sh(vec_angle(m[0] <<< QF, m[3] <<< QF, unused), 12)));
      pending_rsp.push_back(mat);
      pending_rsp.push_back(ang);
   endtask

   task automatic send_item(input req_item_type q, input bit typed,
                            input rsp_item_type typed_mat);
      req_item <= q;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      predict_attitude(q);
      if (typed) pending_rsp[pending_rsp.size() - 2] = typed_mat;
      items_sent++;
      if ($urandom_range(0, 3) != 0) begin
         start <= 1'b0;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 60) : $urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] rnd_unit();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         rsp_seen <= rsp_seen + 1;
         if (pending_rsp.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected item: %p", rsp_item);
         end else begin
            if (rsp_item !== pending_rsp[0]) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected %p actual %p", pending_rsp[0], rsp_item);
            end
            void'(pending_rsp.pop_front());
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_item_type dir[$];
      rsp_item_type mat_fixed[$];
      bit           has_fixed[$];
      req_item_type q;
      rsp_item_type ident;
      real          c, s, th;

      ident = '0;
      ident.slot0 = 16'sd16384;
      ident.slot4 = 16'sd16384;
      ident.slot8 = 16'sd16384;
      dir = '{
         '{16'sd16384, 0, 0, 0, 0, 0, 0},
         '{16'sd16384, 0, 0, 0, 16'sd1024, -16'sd1024, 16'sd512},
         '{0, 16'sd16384, 0, 0, 0, 0, 0},
         '{0, 0, 16'sd16384, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff},
         '{0, 0, 0, 16'sd16384, -16'sh8000, -16'sh8000, -16'sh8000},
         '{0, 0, 0, 0, 0, 0, 0},
         '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
         '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
           -16'sh8000},
         '{-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 1},
         '{16'sd11585, 16'sd11585, 0, 0, 16'sd100, 16'sd200, 16'sd300},
         '{16'sd11585, 0, 16'sd11585, 0, 0, 0, 0},
         '{16'sd11585, 0, -16'sd11585, 0, 0, 0, 0},
         '{16'sd11585, 0, 0, 16'sd11585, 0, 0, 0},
         '{0, 16'sd11585, 16'sd11585, 0, 0, 0, 0},
         '{-16'sd16384, 0, 0, 0, -1, -1, -1},
         '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd5, -16'sd7, 16'sd9},
         '{16'sd1, -16'sd1, 16'sd2, -16'sd2, 0, 16'sd1, 0}
      };
      for (int i = 0; i < dir.size(); i++) begin
         has_fixed.push_back(i == 0 || i == 1);
         mat_fixed.push_back(ident);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir[i]) send_item(dir[i], has_fixed[i], mat_fixed[i]);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 2) begin
            start <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         case ($urandom_range(0, 9))
            0, 1: q = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom)};
            2: q = {rnd_unit(), rnd_unit(), rnd_unit(), rnd_unit(),
                    16'($urandom), 16'($urandom), 16'($urandom)};
            default: begin
               th = ($urandom_range(0, 62831) / 10000.0);
               c = $cos(th / 2.0);
               s = $sin(th / 2.0);
               q.quat_w = 16'($rtoi(c * 16384.0));
               case ($urandom_range(0, 3))
                  0: begin q.quat_x = 16'($rtoi(s * 16384.0)); q.quat_y = 0; q.quat_z = 0; end
                  1: begin q.quat_y = 16'($rtoi(s * 16384.0)); q.quat_x = 0; q.quat_z = 0; end
                  2: begin q.quat_z = 16'($rtoi(s * 16384.0)); q.quat_x = 0; q.quat_y = 0; end
                  default: begin
                     q.quat_x = 16'($rtoi(s * 9459.0));
                     q.quat_y = 16'(-$rtoi(s * 9459.0));
                     q.quat_z = 16'($rtoi(s * 9459.0));
                  end
               endcase
               q.omega_x = 16'($signed($urandom_range(0, 8192)) - 4096);
               q.omega_y = 16'($signed($urandom_range(0, 8192)) - 4096);
               q.omega_z = 16'($signed($urandom_range(0, 8192)) - 4096);
            end
         endcase
         send_item(q, 1'b0, ident);
      end
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("Sent %0d items and checked %0d result items.", items_sent, rsp_seen);
      $display("Covered extreme fields, axis rotations, zero and non-unit quaternions.");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire
